### rtl/kqag_pkg.sv
// Package for the armor quadrilateral geometry block.
// Holds shared constants, output codes and the CORDIC arctangent table.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package kqag_pkg;

	// Parameter defaults
	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int COORD_WIDTH_DEF       = 16;

	// Angle format: Q2.30 held in a signed word with headroom
	localparam int ANG_W       = 35;
	localparam int ATAN_LEN    = 24;
	localparam int PRESCALE_SH = 24;
	localparam logic signed [ANG_W-1:0] ANG_PI      = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd1686629713;

	// Output formats
	localparam int LEN_OUT_W  = 17;
	localparam int RATIO_W    = 16;
	localparam int RATIO_FRAC = 8;
	localparam int RERR_W     = 15;
	localparam int RERR_SH    = 18;

	// Detector ids and color codes
	localparam logic [1:0] ID_BLUE    = 2'd0;
	localparam logic [1:0] ID_RED     = 2'd1;
	localparam logic [1:0] COLOR_BLUE = 2'd0;
	localparam logic [1:0] COLOR_RED  = 2'd1;
	localparam logic [1:0] COLOR_OFF  = 2'd2;
	localparam logic [3:0] NUM_BIG    = 4'd1;

	// atan(2^-i) in Q2.30
	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:  v = 35'sd843314856;
			5'd1:  v = 35'sd497837829;
			5'd2:  v = 35'sd263043836;
			5'd3:  v = 35'sd133525158;
			5'd4:  v = 35'sd67021686;
			5'd5:  v = 35'sd33543515;
			5'd6:  v = 35'sd16775850;
			5'd7:  v = 35'sd8388437;
			5'd8:  v = 35'sd4194282;
			5'd9:  v = 35'sd2097149;
			5'd10: v = 35'sd1048575;
			5'd11: v = 35'sd524287;
			5'd12: v = 35'sd262143;
			5'd13: v = 35'sd131071;
			5'd14: v = 35'sd65535;
			5'd15: v = 35'sd32767;
			5'd16: v = 35'sd16383;
			5'd17: v = 35'sd8191;
			5'd18: v = 35'sd4095;
			5'd19: v = 35'sd2047;
			5'd20: v = 35'sd1023;
			5'd21: v = 35'sd511;
			5'd22: v = 35'sd255;
			5'd23: v = 35'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/keypoint_quad_armor_geometry.sv
// Top level of the armor quadrilateral geometry block.
// Depends on kqag_pkg, kqag_sqrt_cell, kqag_cordic_cell and kqag_div_cell.
//
// Usage:
//   Drive the four keypoints, the ROI offset and the detector ids, and raise
//   start for one cycle per word. busy is always low: a new word is taken at
//   every clock edge where start is high, one quadrilateral per cycle.
//   Each result appears on the result ports for exactly one cycle with done
//   high, after its word has passed the difference, square and sum registers,
//   the square root chain, one cell per root bit (COORD_WIDTH + 1 cells), the
//   rounding and numerator registers, the sixteen-cell ratio divider and the
//   output register; the CORDIC chain of CORDIC_ITERATIONS cells runs alongside
//   and is delayed to line up. Results leave in the order words were taken.
//   The receiver cannot stall the block: done is a one-cycle strobe and the
//   result must be captured in that cycle.
//   Reset clears the valid line only; no word in flight survives it, and
//   done stays low until a word taken after reset reaches the output.
`timescale 1ns / 1ps

module keypoint_quad_armor_geometry #(
	parameter int CORDIC_ITERATIONS = kqag_pkg::CORDIC_ITERATIONS_DEF,
	parameter int COORD_WIDTH       = kqag_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_WIDTH-1:0]       p0_x,
	input  logic signed [COORD_WIDTH-1:0]       p0_y,
	input  logic signed [COORD_WIDTH-1:0]       p1_x,
	input  logic signed [COORD_WIDTH-1:0]       p1_y,
	input  logic signed [COORD_WIDTH-1:0]       p2_x,
	input  logic signed [COORD_WIDTH-1:0]       p2_y,
	input  logic signed [COORD_WIDTH-1:0]       p3_x,
	input  logic signed [COORD_WIDTH-1:0]       p3_y,
	input  logic signed [COORD_WIDTH-1:0]       roi_offset_x,
	input  logic signed [COORD_WIDTH-1:0]       roi_offset_y,
	input  logic [1:0]                          det_color,
	input  logic [3:0]                          number_id,
	output logic                                done,
	output logic signed [COORD_WIDTH-1:0]       center_x,
	output logic signed [COORD_WIDTH-1:0]       center_y,
	output logic [kqag_pkg::LEN_OUT_W-1:0]      max_side_width,
	output logic [kqag_pkg::LEN_OUT_W-1:0]      max_edge_length,
	output logic [kqag_pkg::RATIO_W-1:0]        aspect_ratio,
	output logic [kqag_pkg::RERR_W-1:0]         rect_error,
	output logic [1:0]                          color_code,
	output logic                                is_big,
	output logic                                ratio_saturated
);
	import kqag_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int DW     = W + 1;
	localparam int VW     = W + 2;
	localparam int SQW    = 2 * W;
	localparam int SW     = 2 * W + 1;
	localparam int NB     = W + 1;
	localparam int RW     = 2 * NB;
	localparam int LW     = NB;
	localparam int NUMW   = LW + RATIO_FRAC + 1;
	localparam int RMW    = LW + RATIO_W;
	localparam int XW     = W + 28;
	localparam int EW     = ANG_W + 1;
	localparam int SUMW   = W + 3;
	localparam int D_META = 20 + NB;
	localparam int D_RERR = 19 + W - CORDIC_ITERATIONS;
	localparam int LAT    = 22 + NB;

	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [LW+LEN_OUT_W-1:0] LEN_MAX = (LW+LEN_OUT_W)'({LEN_OUT_W{1'b1}});
	localparam logic [RERR_W-1:0] RERR_MAX = {RERR_W{1'b1}};

	typedef struct packed {
		logic signed [W-1:0] cx;
		logic signed [W-1:0] cy;
		logic [1:0]          color;
		logic                big;
	} meta_t;

	typedef struct packed {
		logic [LEN_OUT_W-1:0] wsat;
		logic [LEN_OUT_W-1:0] lsat;
		logic                 ovf;
	} side_t;

	typedef struct packed {
		logic signed [XW-1:0]    x;
		logic signed [XW-1:0]    y;
		logic signed [ANG_W-1:0] z;
	} cvec_t;

	// Prescale a vector and fold the left half plane onto the right
	function automatic cvec_t cordic_init(input logic signed [VW-1:0] vx,
		input logic signed [VW-1:0] vy);
		cvec_t c;
		c.x = XW'(vx) <<< PRESCALE_SH;
		c.y = XW'(vy) <<< PRESCALE_SH;
		c.z = '0;
		if (vx < 0) begin
			c.z = (vy >= 0) ? ANG_PI : -ANG_PI;
			c.x = -c.x;
			c.y = -c.y;
		end
		return c;
	endfunction

	function automatic logic [LEN_OUT_W-1:0] len_sat(input logic [LW-1:0] v);
		logic [LW+LEN_OUT_W-1:0] e;
		e = (LW+LEN_OUT_W)'(v);
		if (e > LEN_MAX) e = LEN_MAX;
		return e[LEN_OUT_W-1:0];
	endfunction

	assign busy = 1'b0;

	// ---------------- valid line ----------------
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	// ---------------- stage 1: differences, center, CORDIC setup ----------------
	logic signed [DW-1:0] dx_s1 [4];
	logic signed [DW-1:0] dy_s1 [4];
	cvec_t                cv_s1 [3];
	meta_t                meta_s1;

	logic signed [SUMW-1:0] sx;
	logic signed [SUMW-1:0] sy;
	logic signed [SUMW-3:0] cxw;
	logic signed [SUMW-3:0] cyw;
	logic signed [W-1:0]    cx;
	logic signed [W-1:0]    cy;
	logic signed [VW-1:0]   rvx;
	logic signed [VW-1:0]   rvy;

	// Sum offset points, divide by four, clamp
	always_comb begin
		sx = SUMW'(p0_x) + SUMW'(p1_x) + SUMW'(p2_x) + SUMW'(p3_x)
			+ (SUMW'(roi_offset_x) <<< 2);
		sy = SUMW'(p0_y) + SUMW'(p1_y) + SUMW'(p2_y) + SUMW'(p3_y)
			+ (SUMW'(roi_offset_y) <<< 2);
		cxw = sx[SUMW-1:2];
		cyw = sy[SUMW-1:2];
		if (cxw > (SUMW-2)'(CMAX)) cx = CMAX;
		else if (cxw < (SUMW-2)'(CMIN)) cx = CMIN;
		else cx = cxw[W-1:0];
		if (cyw > (SUMW-2)'(CMAX)) cy = CMAX;
		else if (cyw < (SUMW-2)'(CMIN)) cy = CMIN;
		else cy = cyw[W-1:0];
		rvx = (VW'(p1_x) + VW'(p2_x)) - (VW'(p0_x) + VW'(p3_x));
		rvy = (VW'(p1_y) + VW'(p2_y)) - (VW'(p0_y) + VW'(p3_y));
	end

	always_ff @(posedge clk) begin
		dx_s1[0] <= DW'(p0_x) - DW'(p3_x);
		dy_s1[0] <= DW'(p0_y) - DW'(p3_y);
		dx_s1[1] <= DW'(p1_x) - DW'(p2_x);
		dy_s1[1] <= DW'(p1_y) - DW'(p2_y);
		dx_s1[2] <= DW'(p0_x) - DW'(p1_x);
		dy_s1[2] <= DW'(p0_y) - DW'(p1_y);
		dx_s1[3] <= DW'(p3_x) - DW'(p2_x);
		dy_s1[3] <= DW'(p3_y) - DW'(p2_y);
		cv_s1[0] <= cordic_init(rvx, rvy);
		cv_s1[1] <= cordic_init(VW'(p3_x) - VW'(p0_x), VW'(p3_y) - VW'(p0_y));
		cv_s1[2] <= cordic_init(VW'(p2_x) - VW'(p1_x), VW'(p2_y) - VW'(p1_y));
		meta_s1.cx    <= cx;
		meta_s1.cy    <= cy;
		meta_s1.color <= (det_color == ID_BLUE) ? COLOR_BLUE :
			((det_color == ID_RED) ? COLOR_RED : COLOR_OFF);
		meta_s1.big   <= (number_id == NUM_BIG);
	end

	// ---------------- stages 2-3: squares and sums ----------------
	logic [SQW-1:0] sqx_s2 [4];
	logic [SQW-1:0] sqy_s2 [4];
	logic [SW-1:0]  sum_s3 [4];
	logic signed [2*DW-1:0] px [4];
	logic signed [2*DW-1:0] py [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			px[l] = dx_s1[l] * dx_s1[l];
			py[l] = dy_s1[l] * dy_s1[l];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			sqx_s2[l] <= px[l][SQW-1:0];
			sqy_s2[l] <= py[l][SQW-1:0];
			sum_s3[l] <= SW'(sqx_s2[l]) + SW'(sqy_s2[l]);
		end
	end

	// ---------------- square root chain ----------------
	logic [RW-1:0] sqn [NB+1][4];
	logic [RW-1:0] sqr [NB+1][4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			sqn[0][l] = RW'(sum_s3[l]);
			sqr[0][l] = '0;
		end
	end

	for (genvar j = 0; j < NB; j++) begin : g_sqrt
		for (genvar l = 0; l < 4; l++) begin : g_lane
			kqag_sqrt_cell #(
				.RW     (RW),
				.BITPOS (2 * (NB - 1 - j))
			) u_cell (
				.clk   (clk),
				.n_in  (sqn[j][l]),
				.r_in  (sqr[j][l]),
				.n_out (sqn[j+1][l]),
				.r_out (sqr[j+1][l])
			);
		end
	end

	// ---------------- stage 4: round lengths, take maxima ----------------
	logic [LW-1:0] w_s4;
	logic [LW-1:0] l_s4;
	logic [LW-1:0] lenr [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			lenr[l] = sqr[NB][l][LW-1:0];
			if (sqn[NB][l] > sqr[NB][l]) lenr[l] = lenr[l] + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		w_s4 <= (lenr[0] > lenr[1]) ? lenr[0] : lenr[1];
		l_s4 <= (lenr[2] > lenr[3]) ? lenr[2] : lenr[3];
	end

	// ---------------- stage 5: ratio numerator, overflow check ----------------
	logic [NUMW-1:0] num;
	logic [RMW-1:0]  num_s5;
	logic [LW-1:0]   w_s5;
	side_t           side_s5;

	assign num = (NUMW'(l_s4) << RATIO_FRAC) + NUMW'(w_s4 >> 1);

	always_ff @(posedge clk) begin
		num_s5       <= RMW'(num);
		w_s5         <= w_s4;
		side_s5.wsat <= len_sat(w_s4);
		side_s5.lsat <= len_sat(l_s4);
		side_s5.ovf  <= (w_s4 == '0) || (RMW'(num) >= (RMW'(w_s4) << RATIO_W));
	end

	// ---------------- divider chain ----------------
	logic [RMW-1:0]     drem [RATIO_W+1];
	logic [LW-1:0]      ddvs [RATIO_W+1];
	logic [RATIO_W-1:0] dq   [RATIO_W+1];

	assign drem[0] = num_s5;
	assign ddvs[0] = w_s5;
	assign dq[0]   = '0;

	for (genvar j = 0; j < RATIO_W; j++) begin : g_div
		kqag_div_cell #(
			.RMW    (RMW),
			.LW     (LW),
			.BITPOS (RATIO_W - 1 - j)
		) u_cell (
			.clk     (clk),
			.rem_in  (drem[j]),
			.dvs_in  (ddvs[j]),
			.q_in    (dq[j]),
			.rem_out (drem[j+1]),
			.dvs_out (ddvs[j+1]),
			.q_out   (dq[j+1])
		);
	end

	// ---------------- CORDIC chains: roll, left, right ----------------
	logic signed [XW-1:0]    cx_ch [CORDIC_ITERATIONS+1][3];
	logic signed [XW-1:0]    cy_ch [CORDIC_ITERATIONS+1][3];
	logic signed [ANG_W-1:0] cz_ch [CORDIC_ITERATIONS+1][3];

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			cx_ch[0][v] = cv_s1[v].x;
			cy_ch[0][v] = cv_s1[v].y;
			cz_ch[0][v] = cv_s1[v].z;
		end
	end

	for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
		for (genvar v = 0; v < 3; v++) begin : g_vec
			kqag_cordic_cell #(
				.XW  (XW),
				.IDX (i)
			) u_cell (
				.clk   (clk),
				.x_in  (cx_ch[i][v]),
				.y_in  (cy_ch[i][v]),
				.z_in  (cz_ch[i][v]),
				.x_out (cx_ch[i+1][v]),
				.y_out (cy_ch[i+1][v]),
				.z_out (cz_ch[i+1][v])
			);
		end
	end

	// ---------------- angle error: deviation, magnitude, round ----------------
	logic signed [EW-1:0]   el_q;
	logic signed [EW-1:0]   er_q;
	logic [RERR_W-1:0]      rerr_q;
	logic [EW-1:0]          ael;
	logic [EW-1:0]          aer;
	logic [EW-1:0]          emax;
	logic [EW-RERR_SH-1:0]  erd;

	always_comb begin
		ael  = el_q[EW-1] ? EW'(-el_q) : EW'(el_q);
		aer  = er_q[EW-1] ? EW'(-er_q) : EW'(er_q);
		emax = (ael > aer) ? ael : aer;
		erd  = (EW-RERR_SH)'((emax + (EW'(1) << (RERR_SH - 1))) >> RERR_SH);
	end

	always_ff @(posedge clk) begin
		el_q <= EW'(cz_ch[CORDIC_ITERATIONS][1]) - EW'(cz_ch[CORDIC_ITERATIONS][0])
			- EW'(ANG_HALF_PI);
		er_q <= EW'(cz_ch[CORDIC_ITERATIONS][2]) - EW'(cz_ch[CORDIC_ITERATIONS][0])
			- EW'(ANG_HALF_PI);
		rerr_q <= (erd > (EW-RERR_SH)'(RERR_MAX)) ? RERR_MAX : erd[RERR_W-1:0];
	end

	// ---------------- alignment delay lines ----------------
	meta_t             meta_dl_q [D_META];
	logic [RERR_W-1:0] rerr_dl_q [D_RERR];
	side_t             side_dl_q [RATIO_W];

	always_ff @(posedge clk) begin
		meta_dl_q[0] <= meta_s1;
		for (int k = 1; k < D_META; k++) meta_dl_q[k] <= meta_dl_q[k-1];
	end

	always_ff @(posedge clk) begin
		rerr_dl_q[0] <= rerr_q;
		for (int k = 1; k < D_RERR; k++) rerr_dl_q[k] <= rerr_dl_q[k-1];
	end

	always_ff @(posedge clk) begin
		side_dl_q[0] <= side_s5;
		for (int k = 1; k < RATIO_W; k++) side_dl_q[k] <= side_dl_q[k-1];
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		center_x        <= meta_dl_q[D_META-1].cx;
		center_y        <= meta_dl_q[D_META-1].cy;
		color_code      <= meta_dl_q[D_META-1].color;
		is_big          <= meta_dl_q[D_META-1].big;
		max_side_width  <= side_dl_q[RATIO_W-1].wsat;
		max_edge_length <= side_dl_q[RATIO_W-1].lsat;
		ratio_saturated <= side_dl_q[RATIO_W-1].ovf;
		aspect_ratio    <= side_dl_q[RATIO_W-1].ovf ? {RATIO_W{1'b1}} : dq[RATIO_W];
		rect_error      <= rerr_dl_q[D_RERR-1];
	end

	assign done = vld_q[LAT-1];

`ifndef SYNTHESIS
	// A result leaves exactly the pipeline latency after its word was taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching word");

	// A zero side width always flags the ratio
	a_zero_width: assert property (@(posedge clk) disable iff (!arst_n)
		(done && max_side_width == '0) |-> ratio_saturated)
		else $error("zero width without saturation flag");

	// Color code never takes the unused value
	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (color_code == COLOR_BLUE || color_code == COLOR_RED
			|| color_code == COLOR_OFF))
		else $error("bad color code");
`endif

endmodule

### rtl/kqag_sqrt_cell.sv
// One cell of the bit-serial square root chain: settles one result bit.
// Depends on kqag_pkg (imported for project consistency of formats).
`timescale 1ns / 1ps

module kqag_sqrt_cell #(
	parameter int RW     = 34,
	parameter int BITPOS = 32
) (
	input  logic          clk,
	input  logic [RW-1:0] n_in,
	input  logic [RW-1:0] r_in,
	output logic [RW-1:0] n_out,
	output logic [RW-1:0] r_out
);
	import kqag_pkg::*;

	localparam logic [RW-1:0] BIT = RW'(1) << BITPOS;

	logic [RW-1:0] trial;
	logic [RW-1:0] n_d;
	logic [RW-1:0] r_d;

	// Try subtracting the partial root plus this bit
	always_comb begin
		trial = r_in + BIT;
		if (n_in >= trial) begin
			n_d = n_in - trial;
			r_d = (r_in >> 1) + BIT;
		end else begin
			n_d = n_in;
			r_d = r_in >> 1;
		end
	end

	// Hand the remainder and root to the next cell
	always_ff @(posedge clk) begin
		n_out <= n_d;
		r_out <= r_d;
	end

endmodule

### rtl/kqag_cordic_cell.sv
// One micro-rotation of the CORDIC vectoring chain.
// Depends on kqag_pkg for the angle width and arctangent table.
`timescale 1ns / 1ps

module kqag_cordic_cell #(
	parameter int XW  = 44,
	parameter int IDX = 0
) (
	input  logic                            clk,
	input  logic signed [XW-1:0]            x_in,
	input  logic signed [XW-1:0]            y_in,
	input  logic signed [kqag_pkg::ANG_W-1:0] z_in,
	output logic signed [XW-1:0]            x_out,
	output logic signed [XW-1:0]            y_out,
	output logic signed [kqag_pkg::ANG_W-1:0] z_out
);
	import kqag_pkg::*;

	localparam logic signed [ANG_W-1:0] ATAN = atan_entry(5'(IDX));

	logic signed [XW-1:0]    x_d;
	logic signed [XW-1:0]    y_d;
	logic signed [ANG_W-1:0] z_d;

	// Rotate toward the x axis; hold when already on it
	always_comb begin
		if (y_in > 0) begin
			x_d = x_in + (y_in >>> IDX);
			y_d = y_in - (x_in >>> IDX);
			z_d = z_in + ATAN;
		end else if (y_in < 0) begin
			x_d = x_in - (y_in >>> IDX);
			y_d = y_in + (x_in >>> IDX);
			z_d = z_in - ATAN;
		end else begin
			x_d = x_in;
			y_d = y_in;
			z_d = z_in;
		end
	end

	always_ff @(posedge clk) begin
		x_out <= x_d;
		y_out <= y_d;
		z_out <= z_d;
	end

endmodule

### rtl/kqag_div_cell.sv
// One restoring-division cell of the ratio chain: settles one quotient bit.
// Depends on kqag_pkg for the quotient width.
`timescale 1ns / 1ps

module kqag_div_cell #(
	parameter int RMW    = 33,
	parameter int LW     = 17,
	parameter int BITPOS = 15
) (
	input  logic                           clk,
	input  logic [RMW-1:0]                 rem_in,
	input  logic [LW-1:0]                  dvs_in,
	input  logic [kqag_pkg::RATIO_W-1:0]   q_in,
	output logic [RMW-1:0]                 rem_out,
	output logic [LW-1:0]                  dvs_out,
	output logic [kqag_pkg::RATIO_W-1:0]   q_out
);
	import kqag_pkg::*;

	logic [RMW-1:0]     dsh;
	logic [RMW-1:0]     rem_d;
	logic [RATIO_W-1:0] q_d;

	// Subtract the shifted divisor when it fits
	always_comb begin
		dsh = RMW'(dvs_in) << BITPOS;
		if (rem_in >= dsh) begin
			rem_d = rem_in - dsh;
			q_d   = q_in | (RATIO_W'(1) << BITPOS);
		end else begin
			rem_d = rem_in;
			q_d   = q_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_out <= rem_d;
		dvs_out <= dvs_in;
		q_out   <= q_d;
	end

endmodule
